// ===== hdl/stq_pkg.sv =====
`default_nettype none

package stq_pkg;

  localparam int unsigned SLOT_W = 4;
  localparam int unsigned REF_W  = 16;
  localparam int unsigned TIME_W = 32;

  typedef enum logic [1:0] {
    CMD_ARM    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_EXPIRE = 2'd2,
    CMD_UNUSED = 2'd3
  } stq_cmd_e;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRED  = 1'b1;

  // Operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_INSERT = 2'd2,
    OP_POP    = 2'd3
  } stq_op_e;

  typedef struct packed {
    stq_op_e           op;
    logic [SLOT_W-1:0] key_slot;
    logic [REF_W-1:0]  new_ref;
  } stq_ctrl_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [SLOT_W-1:0] timer_slot;
    logic [TIME_W-1:0] deadline;
    logic [REF_W-1:0]  owner_ref;
    logic [TIME_W-1:0] now;
  } stq_in_t;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] fired_slot;
    logic [REF_W-1:0]  fired_ref;
    logic              due;
    logic              has_pending;
    logic [TIME_W-1:0] next_deadline;
    logic              last_of_run;
  } stq_out_t;

endpackage

`default_nettype wire

// ===== hdl/stq_cell.sv =====
`default_nettype none

module stq_cell import stq_pkg::*; #(
  parameter int unsigned DL_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire stq_ctrl_t          ctrl_i,
  input  wire logic               head_i,
  input  wire logic [DL_BITS-1:0] new_dl_i,
  input  wire logic               prev_valid_i,
  input  wire logic               prev_keep_i,
  input  wire logic [DL_BITS-1:0] prev_dl_i,
  input  wire logic [SLOT_W-1:0]  prev_slot_i,
  input  wire logic [REF_W-1:0]   prev_ref_i,
  input  wire logic               hit_i,
  input  wire logic               next_valid_i,
  input  wire logic [DL_BITS-1:0] next_dl_i,
  input  wire logic [SLOT_W-1:0]  next_slot_i,
  input  wire logic [REF_W-1:0]   next_ref_i,
  output logic                    valid_o,
  output logic                    keep_o,
  output logic                    hit_o,
  output logic [DL_BITS-1:0]      dl_o,
  output logic [SLOT_W-1:0]       slot_o,
  output logic [REF_W-1:0]        ref_o
);

  logic               valid_q, valid_d;
  logic [DL_BITS-1:0] dl_q, dl_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [REF_W-1:0]   ref_q, ref_d;
  logic               match;

  // Removal point propagates towards the tail
  assign match  = valid_q && (slot_q == ctrl_i.key_slot);
  assign hit_o  = hit_i | match;
  // The head also keeps its place on a tie
  assign keep_o = valid_q && (head_i ? (dl_q <= new_dl_i) : (dl_q < new_dl_i));

  always_comb begin
    valid_d = valid_q;
    dl_d    = dl_q;
    slot_d  = slot_q;
    ref_d   = ref_q;
    unique case (ctrl_i.op)
      OP_HOLD: begin
      end
      OP_REMOVE, OP_POP: begin
        if (hit_o || (ctrl_i.op == OP_POP)) begin
          valid_d = next_valid_i;
          dl_d    = next_dl_i;
          slot_d  = next_slot_i;
          ref_d   = next_ref_i;
        end
      end
      OP_INSERT: begin
        if (!keep_o) begin
          if (head_i || prev_keep_i) begin
            valid_d = 1'b1;
            dl_d    = new_dl_i;
            slot_d  = ctrl_i.key_slot;
            ref_d   = ctrl_i.new_ref;
          end else begin
            valid_d = prev_valid_i;
            dl_d    = prev_dl_i;
            slot_d  = prev_slot_i;
            ref_d   = prev_ref_i;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q   <= dl_d;
    slot_q <= slot_d;
    ref_q  <= ref_d;
  end

  assign valid_o = valid_q;
  assign dl_o    = dl_q;
  assign slot_o  = slot_q;
  assign ref_o   = ref_q;

endmodule

`default_nettype wire

// ===== hdl/sorted_timer_queue.sv =====
// Sorted timer queue: arm runs remove, insert and status; cancel runs remove and status;
// command 3 or a bad slot goes straight to status; expire pops each fired timer and then
// sends the status beat; an output stall can hold the pops and the status beat. A sequencer
// drives the whole cell chain with one remove, insert or pop per cycle, a pop only while the
// output register is free. Expire ends with a step that sees the head is no longer due. One
// command at a time; the next is taken once the status beat sits in the output register. Reset
// clears every cell valid bit, the due flag and the output valid bit.
`default_nettype none

module sorted_timer_queue import stq_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 16,
  parameter int unsigned TIME_BITS  = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire stq_in_t  in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output stq_out_t      out_item_o
);

  // Deadlines and now are carried at the narrower of the time base and the field width
  localparam int unsigned TW = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REMOVE = 5'b00010,
    S_INSERT = 5'b00100,
    S_EXPIRE = 5'b01000,
    S_STATUS = 5'b10000
  } stq_state_e;

  stq_state_e state_q, state_d;

  // Latched command
  stq_cmd_e          cmd_q;
  logic              check_q;
  logic [SLOT_W-1:0] slot_q;
  logic [TW-1:0]     dl_q;
  logic [REF_W-1:0]  ref_q;
  logic [TW-1:0]     now_q;
  logic              due_q, due_d;

  // Output register
  logic     out_valid_q, out_valid_d;
  stq_out_t out_q, out_d;
  logic     out_free;

  // Chain taps
  logic [NUM_TIMERS-1:0] valid_w, keep_w, hit_w;
  logic [TW-1:0]         dl_w   [NUM_TIMERS];
  logic [SLOT_W-1:0]     slot_w [NUM_TIMERS];
  logic [REF_W-1:0]      ref_w  [NUM_TIMERS];

  stq_ctrl_t ctrl;
  logic      in_accept;
  logic      slot_ok;
  logic      head_due;
  stq_cmd_e  in_cmd;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_cmd     = stq_cmd_e'(in_item_i.command);
  assign slot_ok    = (int'(in_item_i.timer_slot) < int'(NUM_TIMERS));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign head_due   = valid_w[0] && (dl_w[0] <= now_q);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      slot_q <= in_item_i.timer_slot;
      dl_q   <= in_item_i.deadline[TW-1:0];
      ref_q  <= in_item_i.owner_ref;
      now_q  <= in_item_i.now[TW-1:0];
    end
  end

  // Sequencer: one chain operation per cycle, a pop only while the output register is free
  always_comb begin
    state_d       = state_q;
    due_d         = due_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_d         = out_q;
    ctrl.op       = OP_HOLD;
    ctrl.key_slot = slot_q;
    ctrl.new_ref  = ref_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          priority if (((in_cmd == CMD_ARM) || (in_cmd == CMD_CANCEL)) && slot_ok) begin
            state_d = S_REMOVE;
          end else if (in_cmd == CMD_EXPIRE) begin
            state_d = S_EXPIRE;
          end else begin
            state_d = S_STATUS;
          end
        end
      end
      S_REMOVE: begin
        ctrl.op = OP_REMOVE;
        state_d = (cmd_q == CMD_ARM) ? S_INSERT : S_STATUS;
      end
      S_INSERT: begin
        ctrl.op = OP_INSERT;
        state_d = S_STATUS;
      end
      S_EXPIRE: begin
        // Pop the head while it is due and the output register can take the beat
        if (head_due) begin
          if (out_free) begin
            ctrl.op           = OP_POP;
            out_valid_d       = 1'b1;
            out_d             = '0;
            out_d.kind        = KIND_FIRED;
            out_d.fired_slot  = slot_w[0];
            out_d.fired_ref   = ref_w[0];
          end
        end else begin
          state_d = S_STATUS;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          if (check_q) begin
            due_d = (cmd_q == CMD_EXPIRE) ? head_due : (due_q | head_due);
          end
          out_valid_d         = 1'b1;
          out_d               = '0;
          out_d.kind          = KIND_STATUS;
          out_d.due           = check_q ? due_d : due_q;
          out_d.has_pending   = valid_w[0];
          out_d.next_deadline = valid_w[0] ? TIME_W'(dl_w[0]) : '0;
          out_d.last_of_run   = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      due_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cmd_q       <= CMD_UNUSED;
      check_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      due_q       <= due_d;
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        cmd_q   <= in_cmd;
        // Arm and cancel on a real slot, and expire, rerun the due check
        check_q <= (((in_cmd == CMD_ARM) || (in_cmd == CMD_CANCEL)) && slot_ok) ||
                   (in_cmd == CMD_EXPIRE);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Chain of cells, head at index zero
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    logic              pv, pk, nv, hin;
    logic [TW-1:0]     pdl, ndl;
    logic [SLOT_W-1:0] pslot, nslot;
    logic [REF_W-1:0]  pref, nref;

    if (i == 0) begin : g_head
      assign pv    = 1'b0;
      assign pk    = 1'b0;
      assign pdl   = '0;
      assign pslot = '0;
      assign pref  = '0;
      assign hin   = 1'b0;
    end else begin : g_body
      assign pv    = valid_w[i-1];
      assign pk    = keep_w[i-1];
      assign pdl   = dl_w[i-1];
      assign pslot = slot_w[i-1];
      assign pref  = ref_w[i-1];
      assign hin   = hit_w[i-1];
    end

    if (i == NUM_TIMERS - 1) begin : g_tail
      assign nv    = 1'b0;
      assign ndl   = '0;
      assign nslot = '0;
      assign nref  = '0;
    end else begin : g_link
      assign nv    = valid_w[i+1];
      assign ndl   = dl_w[i+1];
      assign nslot = slot_w[i+1];
      assign nref  = ref_w[i+1];
    end

    stq_cell #(
      .DL_BITS(TW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .head_i      (1'(i == 0)),
      .new_dl_i    (dl_q),
      .prev_valid_i(pv),
      .prev_keep_i (pk),
      .prev_dl_i   (pdl),
      .prev_slot_i (pslot),
      .prev_ref_i  (pref),
      .hit_i       (hin),
      .next_valid_i(nv),
      .next_dl_i   (ndl),
      .next_slot_i (nslot),
      .next_ref_i  (nref),
      .valid_o     (valid_w[i]),
      .keep_o      (keep_w[i]),
      .hit_o       (hit_w[i]),
      .dl_o        (dl_w[i]),
      .slot_o      (slot_w[i]),
      .ref_o       (ref_w[i])
    );
  end

  // Occupied cells always form an unbroken run from the head
  a_chain_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_w & (valid_w + 1'b1)) == '0))
    else $error("chain has a hole");

  // Only the status beat closes a run
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.last_of_run == (out_item_o.kind == KIND_STATUS)))
    else $error("last_of_run does not match kind");

  // An insert never meets a full chain
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INSERT) |-> !keep_w[NUM_TIMERS-1])
    else $error("insert into full chain");

  // A successful removal always frees the tail cell
  a_remove_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_REMOVE) && hit_w[NUM_TIMERS-1]) |=> !valid_w[NUM_TIMERS-1])
    else $error("removal left tail occupied");

endmodule

`default_nettype wire
